### rtl/rob_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rob_pkg
// shared types and constants of the reorder buffer: operation and status
// codes, sequencer states and the control/status groups of one entry cell
// ----------------------------------------------------------------------------
package rob_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int TAG_BITS_DEF = 16;

	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;
	localparam int TAG_OUT_W = 16;
	localparam int DEST_W  = 5;
	localparam int VALUE_W = 32;

	typedef enum logic [OP_W-1:0] {
		OP_ENQ    = 2'd0,
		OP_DEQ    = 2'd1,
		OP_BCAST  = 2'd2,
		OP_LOOKUP = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_MISS  = 2'd3
	} status_t;

	typedef enum logic {
		SEQ_IDLE = 1'b0,
		SEQ_SCAN = 1'b1
	} seq_state_t;

	typedef struct packed {
		logic enq;
		logic deq;
		logic bcast;
		logic start;
		logic step;
	} cell_ctrl_t;

	typedef struct packed {
		logic valid;
		logic ready;
		logic probe;
		logic bc_hit;
		logic lu_hit;
		logic live;
	} cell_stat_t;

endpackage

### rtl/rob_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rob_cell
// one reorder buffer entry: holds tag, destination, value and ready mark,
// shifts toward the head on dequeue and passes the lookup probe along
// ----------------------------------------------------------------------------
module rob_cell import rob_pkg::*; #(
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cell_ctrl_t                 ctrl,
	input  logic [TAG_BITS-1:0]        key,
	input  logic [TAG_BITS-1:0]        new_tag,
	input  logic [DEST_W-1:0]          new_dest,
	input  logic signed [VALUE_W-1:0]  bus_value,
	input  logic                       left_valid,
	input  logic                       probe_in,
	input  logic                       nb_valid,
	input  logic                       nb_ready,
	input  logic [TAG_BITS-1:0]        nb_tag,
	input  logic [DEST_W-1:0]          nb_dest,
	input  logic signed [VALUE_W-1:0]  nb_value,
	output cell_stat_t                 stat,
	output logic [TAG_BITS-1:0]        tag_q,
	output logic [DEST_W-1:0]          dest_q,
	output logic signed [VALUE_W-1:0]  value_q,
	output logic signed [VALUE_W-1:0]  sel_value
);

	logic valid_q;
	logic ready_q;
	logic probe_q;
	logic tag_eq;
	logic load;
	logic fill;

	assign tag_eq = (tag_q == key);
	assign load   = ctrl.enq & ~valid_q & left_valid;
	assign fill   = ctrl.bcast & valid_q & ~ready_q & tag_eq;

	assign stat.valid  = valid_q;
	assign stat.ready  = ready_q;
	assign stat.probe  = probe_q;
	assign stat.bc_hit = fill;
	assign stat.lu_hit = probe_q & valid_q & ready_q & tag_eq;
	assign stat.live   = probe_q & valid_q;

	assign sel_value = stat.lu_hit ? value_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ready_q <= 1'b0;
			probe_q <= 1'b0;
		end else begin
			if (ctrl.deq) begin
				valid_q <= nb_valid;
				ready_q <= nb_ready;
			end else if (load) begin
				valid_q <= 1'b1;
				ready_q <= 1'b0;
			end else if (fill) begin
				ready_q <= 1'b1;
			end
			if (ctrl.start || ctrl.step) begin
				probe_q <= probe_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.deq) begin
			tag_q   <= nb_tag;
			dest_q  <= nb_dest;
			value_q <= nb_value;
		end else if (load) begin
			tag_q   <= new_tag;
			dest_q  <= new_dest;
			value_q <= '0;
		end else if (fill) begin
			value_q <= bus_value;
		end
	end

endmodule

### rtl/reorder_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reorder_buffer
// reorder buffer built as a row of entry cells, head at cell zero: enqueue,
// dequeue, result broadcast and lookup by tag, one result word per input word
// ----------------------------------------------------------------------------
// enqueue, dequeue and broadcast: the result is registered as the input word is
// taken; next word taken in the following cycle unless the output stalls
// lookup: a probe walks the cells one per cycle from the head while the
// output does not stall, and stops at the oldest ready match or a free cell
// reset: all entries empty and not ready, tag counter zero, no result pending
// ----------------------------------------------------------------------------
module reorder_buffer import rob_pkg::*; #(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [OP_W-1:0]            opcode,
	input  logic [DEST_W-1:0]          dest_reg,
	input  logic [TAG_OUT_W-1:0]       tag,
	input  logic signed [VALUE_W-1:0]  bus_value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [STAT_W-1:0]          status,
	output logic [TAG_OUT_W-1:0]       tag_out,
	output logic [DEST_W-1:0]          dest_out,
	output logic signed [VALUE_W-1:0]  value_out,
	output logic                       ready_out
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	seq_state_t                 state_q, state_d;
	cell_ctrl_t                 ctrl;
	cell_stat_t                 cst [DEPTH];
	logic [TAG_BITS-1:0]        c_tag [DEPTH];
	logic [DEST_W-1:0]          c_dest [DEPTH];
	logic signed [VALUE_W-1:0]  c_value [DEPTH];
	logic signed [VALUE_W-1:0]  c_sel [DEPTH];
	logic                       probe_in [DEPTH];

	logic [CNT_W-1:0]           count_q;
	logic [TAG_BITS-1:0]        last_tag_q;
	logic [TAG_BITS-1:0]        next_tag;
	logic [TAG_BITS-1:0]        key_q;
	logic [TAG_BITS-1:0]        in_key;
	logic [TAG_BITS-1:0]        cell_key;

	logic                       accept;
	logic                       out_free;
	logic                       full;
	logic                       empty;
	logic                       any_bc;
	logic                       any_lu;
	logic                       any_live;
	logic signed [VALUE_W-1:0]  lu_value;

	logic                       out_load;
	status_t                    res_status;
	logic [TAG_OUT_W-1:0]       res_tag;
	logic [DEST_W-1:0]          res_dest;
	logic signed [VALUE_W-1:0]  res_value;
	logic                       res_ready;

	logic                       out_valid_q;
	logic [STAT_W-1:0]          status_q;
	logic [TAG_OUT_W-1:0]       tag_out_q;
	logic [DEST_W-1:0]          dest_out_q;
	logic signed [VALUE_W-1:0]  value_out_q;
	logic                       ready_out_q;

	assign in_key   = TAG_BITS'(tag);
	assign cell_key = (state_q == SEQ_SCAN) ? key_q : in_key;
	assign next_tag = last_tag_q + TAG_BITS'(1);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign out_free = ~out_valid_q | ~out_stall;
	assign in_stall = (state_q != SEQ_IDLE) | ~out_free;
	assign accept   = in_valid & ~in_stall;

	// row of entry cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                      left_v;
		logic                      nb_v;
		logic                      nb_r;
		logic [TAG_BITS-1:0]       nb_t;
		logic [DEST_W-1:0]         nb_d;
		logic signed [VALUE_W-1:0] nb_val;

		if (i == 0) begin : g_head
			assign left_v      = 1'b1;
			assign probe_in[i] = ctrl.start;
		end else begin : g_body
			assign left_v      = cst[i-1].valid;
			assign probe_in[i] = ctrl.step & cst[i-1].probe;
		end

		if (i == DEPTH - 1) begin : g_tail
			assign nb_v   = 1'b0;
			assign nb_r   = 1'b0;
			assign nb_t   = '0;
			assign nb_d   = '0;
			assign nb_val = '0;
		end else begin : g_next
			assign nb_v   = cst[i+1].valid;
			assign nb_r   = cst[i+1].ready;
			assign nb_t   = c_tag[i+1];
			assign nb_d   = c_dest[i+1];
			assign nb_val = c_value[i+1];
		end

		rob_cell #(
			.TAG_BITS (TAG_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.key        (cell_key),
			.new_tag    (next_tag),
			.new_dest   (dest_reg),
			.bus_value  (bus_value),
			.left_valid (left_v),
			.probe_in   (probe_in[i]),
			.nb_valid   (nb_v),
			.nb_ready   (nb_r),
			.nb_tag     (nb_t),
			.nb_dest    (nb_d),
			.nb_value   (nb_val),
			.stat       (cst[i]),
			.tag_q      (c_tag[i]),
			.dest_q     (c_dest[i]),
			.value_q    (c_value[i]),
			.sel_value  (c_sel[i])
		);
	end

	always_comb begin
		any_bc   = 1'b0;
		any_lu   = 1'b0;
		any_live = 1'b0;
		lu_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			any_bc   = any_bc | cst[i].bc_hit;
			any_lu   = any_lu | cst[i].lu_hit;
			any_live = any_live | cst[i].live;
			lu_value = lu_value | c_sel[i];
		end
	end

	// sequencer
	always_comb begin
		state_d    = state_q;
		ctrl       = '0;
		out_load   = 1'b0;
		res_status = STAT_OK;
		res_tag    = '0;
		res_dest   = '0;
		res_value  = '0;
		res_ready  = 1'b0;
		unique case (state_q)
			SEQ_IDLE: begin
				if (accept) begin
					unique case (op_t'(opcode))
						OP_ENQ: begin
							out_load = 1'b1;
							if (full) begin
								res_status = STAT_FULL;
							end else begin
								ctrl.enq = 1'b1;
								res_tag  = TAG_OUT_W'(next_tag);
							end
						end
						OP_DEQ: begin
							out_load = 1'b1;
							if (empty) begin
								res_status = STAT_EMPTY;
							end else begin
								ctrl.deq  = 1'b1;
								res_tag   = TAG_OUT_W'(c_tag[0]);
								res_dest  = c_dest[0];
								res_value = c_value[0];
								res_ready = cst[0].ready;
							end
						end
						OP_BCAST: begin
							out_load   = 1'b1;
							ctrl.bcast = 1'b1;
							res_status = any_bc ? STAT_OK : STAT_MISS;
							res_tag    = TAG_OUT_W'(in_key);
						end
						OP_LOOKUP: begin
							ctrl.start = 1'b1;
							state_d    = SEQ_SCAN;
						end
						default: begin
						end
					endcase
				end
			end
			SEQ_SCAN: begin
				res_tag = TAG_OUT_W'(key_q);
				if (out_free) begin
					if (any_lu) begin
						out_load   = 1'b1;
						res_status = STAT_OK;
						res_value  = lu_value;
						state_d    = SEQ_IDLE;
					end else if (!any_live) begin
						out_load   = 1'b1;
						res_status = STAT_MISS;
						state_d    = SEQ_IDLE;
					end else begin
						ctrl.step = 1'b1;
					end
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			count_q     <= '0;
			last_tag_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.enq) begin
				count_q    <= count_q + CNT_W'(1);
				last_tag_q <= next_tag;
			end else if (ctrl.deq) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			key_q <= in_key;
		end
		if (out_load) begin
			status_q    <= res_status;
			tag_out_q   <= res_tag;
			dest_out_q  <= res_dest;
			value_out_q <= res_value;
			ready_out_q <= res_ready;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign tag_out   = tag_out_q;
	assign dest_out  = dest_out_q;
	assign value_out = value_out_q;
	assign ready_out = ready_out_q;

endmodule
